// ===== sv/tlr_pkg.sv =====
package tlr_pkg;

    localparam int COORD_BITS = 14;
    localparam int MAX_BRUSH  = 64;

    localparam int SPAN_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int BRUSH_BITS = (MAX_BRUSH > 1) ? $clog2(MAX_BRUSH) : 1;
    localparam int SIZE_BITS  = 7;
    localparam int FRAME_BITS = 13;
    localparam int COLOR_BITS = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam int OUT_RAW_BITS = 2 * SPAN_BITS + 1 + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int IN_DATA_BITS  = 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_X      = 3'd0,
        REG_START_Y      = 3'd1,
        REG_END_X        = 3'd2,
        REG_END_Y        = 3'd3,
        REG_BRUSH_SIZE   = 3'd4,
        REG_FRAME_WIDTH  = 3'd5,
        REG_FRAME_HEIGHT = 3'd6,
        REG_DRAW_COLOR   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [SIZE_BITS-1:0]         brush_size;
        logic [FRAME_BITS-1:0]        frame_width;
        logic [FRAME_BITS-1:0]        frame_height;
        logic [COLOR_BITS-1:0]        draw_color;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] walk_x;
        logic signed [COORD_BITS-1:0] walk_y;
        logic signed [ERR_BITS-1:0]   error_term;
        logic signed [SPAN_BITS-1:0]  span_x;
        logic signed [SPAN_BITS-1:0]  span_y_neg;
        logic                         step_x_neg;
        logic                         step_y_neg;
        logic [BRUSH_BITS-1:0]        brush_col;
        logic [BRUSH_BITS-1:0]        brush_row;
        logic                         busy;
    } walk_t;

    typedef struct packed {
        logic signed [SPAN_BITS-1:0] pixel_x;
        logic signed [SPAN_BITS-1:0] pixel_y;
        logic                        write_enable;
        logic [COLOR_BITS-1:0]       pixel_color;
        logic                        last;
        logic                        idle;
    } pixel_t;

endpackage

// ===== sv/tlr_step.sv =====
module tlr_step (
    input  tlr_pkg::cfg_t   cfg_i,
    input  tlr_pkg::walk_t  walk_i,
    input  logic            restart_i,
    output tlr_pkg::walk_t  walk_o,
    output tlr_pkg::pixel_t pixel_o
);
    import tlr_pkg::*;

    localparam int CMP_BITS = (SPAN_BITS > FRAME_BITS) ? SPAN_BITS : FRAME_BITS;
    localparam int E2_BITS  = ERR_BITS + 1;

    walk_t                        loaded;
    walk_t                        cur;
    logic signed [SPAN_BITS-1:0]  dx;
    logic signed [SPAN_BITS-1:0]  dy;
    logic signed [SPAN_BITS-1:0]  px;
    logic signed [SPAN_BITS-1:0]  py;
    logic                         in_frame;
    logic                         we;
    logic [SIZE_BITS-1:0]         size_cl;
    logic [SIZE_BITS-1:0]         n;
    logic                         row_more;
    logic                         col_more;
    logic                         at_end;
    logic signed [E2_BITS-1:0]    e2;
    logic                         move_x;
    logic                         move_y;
    logic signed [E2_BITS-1:0]    err_sum;

    // walk loaded from the registers on restart
    always_comb begin
        dx = SPAN_BITS'(cfg_i.end_x) - SPAN_BITS'(cfg_i.start_x);
        dy = SPAN_BITS'(cfg_i.end_y) - SPAN_BITS'(cfg_i.start_y);
        loaded.walk_x     = cfg_i.start_x;
        loaded.walk_y     = cfg_i.start_y;
        loaded.span_x     = dx[SPAN_BITS-1] ? -dx : dx;
        loaded.span_y_neg = dy[SPAN_BITS-1] ? dy : -dy;
        loaded.step_x_neg = !(cfg_i.start_x < cfg_i.end_x);
        loaded.step_y_neg = !(cfg_i.start_y < cfg_i.end_y);
        loaded.error_term = ERR_BITS'(loaded.span_x) + ERR_BITS'(loaded.span_y_neg);
        loaded.brush_col  = '0;
        loaded.brush_row  = '0;
        loaded.busy       = 1'b1;
        cur = restart_i ? loaded : walk_i;
    end

    always_comb begin
        size_cl = (cfg_i.brush_size > SIZE_BITS'(MAX_BRUSH)) ? SIZE_BITS'(MAX_BRUSH)
                                                             : cfg_i.brush_size;
        n = (size_cl == '0) ? SIZE_BITS'(1) : size_cl;

        px = SPAN_BITS'(cur.walk_x) + SPAN_BITS'($signed({1'b0, cur.brush_col}));
        py = SPAN_BITS'(cur.walk_y) + SPAN_BITS'($signed({1'b0, cur.brush_row}));
        in_frame = !px[SPAN_BITS-1] && !py[SPAN_BITS-1] &&
                   (CMP_BITS'(px[SPAN_BITS-2:0]) < CMP_BITS'(cfg_i.frame_width)) &&
                   (CMP_BITS'(py[SPAN_BITS-2:0]) < CMP_BITS'(cfg_i.frame_height));
        we = in_frame && (size_cl != '0);

        row_more = (SIZE_BITS'(cur.brush_row) + SIZE_BITS'(1)) < n;
        col_more = (SIZE_BITS'(cur.brush_col) + SIZE_BITS'(1)) < n;
        at_end   = (cur.walk_x == cfg_i.end_x) && (cur.walk_y == cfg_i.end_y);

        e2 = {cur.error_term, 1'b0};
        move_x = e2 >= E2_BITS'(cur.span_y_neg);
        move_y = e2 <= E2_BITS'(cur.span_x);
        err_sum = E2_BITS'(cur.error_term)
                + (move_x ? E2_BITS'(cur.span_y_neg) : E2_BITS'(0))
                + (move_y ? E2_BITS'(cur.span_x) : E2_BITS'(0));

        walk_o  = cur;
        pixel_o = '0;
        if (!cur.busy) begin
            pixel_o.idle = 1'b1;
        end else begin
            pixel_o.pixel_x      = px;
            pixel_o.pixel_y      = py;
            pixel_o.write_enable = we;
            pixel_o.pixel_color  = we ? cfg_i.draw_color : '0;
            if (row_more) begin
                walk_o.brush_row = cur.brush_row + BRUSH_BITS'(1);
            end else begin
                walk_o.brush_row = '0;
                if (col_more) begin
                    walk_o.brush_col = cur.brush_col + BRUSH_BITS'(1);
                end else begin
                    walk_o.brush_col = '0;
                    if (at_end) begin
                        pixel_o.last = 1'b1;
                        walk_o.busy  = 1'b0;
                    end else begin
                        walk_o.error_term = err_sum[ERR_BITS-1:0];
                        if (move_x) begin
                            walk_o.walk_x = cur.walk_x +
                                (cur.step_x_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
                        end
                        if (move_y) begin
                            walk_o.walk_y = cur.walk_y +
                                (cur.step_y_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== sv/thick_line_rasterizer_top.sv =====
// the pixel for an accepted input transfer is registered and shows on the master side in the cycle after it
// throughput: one pixel per cycle if unstalled, set by the single pass from walk state to output register
// the output register stalls the input side only while a pixel waits and m_tready is low
// reset: aresetn low clears the walk to idle, loads register defaults, empties the output
module thick_line_rasterizer_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [tlr_pkg::IN_DATA_BITS-1:0]        s_tdata,   // restart
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [tlr_pkg::OUT_DATA_BITS-1:0]       m_tdata,   // pixel_x, pixel_y, write_enable, pixel_color
    output logic                                    m_tlast,
    output logic                                    m_tuser,   // idle
    input  logic                                    cfg_we,
    input  logic [tlr_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [tlr_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
    import tlr_pkg::*;

    cfg_t   cfg_reg;
    walk_t  walk_reg;
    walk_t  walk_next;
    pixel_t pixel_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic [OUT_DATA_BITS-1:0] m_data_reg;
    logic [OUT_DATA_BITS-1:0] m_data_next;
    logic   m_last_reg;
    logic   m_user_reg;
    logic   s_fire;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x      <= '0;
            cfg_reg.start_y      <= '0;
            cfg_reg.end_x        <= '0;
            cfg_reg.end_y        <= '0;
            cfg_reg.brush_size   <= SIZE_BITS'(1);
            cfg_reg.frame_width  <= FRAME_BITS'(1024);
            cfg_reg.frame_height <= FRAME_BITS'(768);
            cfg_reg.draw_color   <= '0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_START_X:      cfg_reg.start_x      <= cfg_data[COORD_BITS-1:0];
                REG_START_Y:      cfg_reg.start_y      <= cfg_data[COORD_BITS-1:0];
                REG_END_X:        cfg_reg.end_x        <= cfg_data[COORD_BITS-1:0];
                REG_END_Y:        cfg_reg.end_y        <= cfg_data[COORD_BITS-1:0];
                REG_BRUSH_SIZE:   cfg_reg.brush_size   <= cfg_data[SIZE_BITS-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[FRAME_BITS-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[FRAME_BITS-1:0];
                REG_DRAW_COLOR:   cfg_reg.draw_color   <= cfg_data[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    tlr_step u_step (
        .cfg_i     (cfg_reg),
        .walk_i    (walk_reg),
        .restart_i (s_tdata[0]),
        .walk_o    (walk_next),
        .pixel_o   (pixel_next)
    );

    always_comb begin
        m_data_next = OUT_DATA_BITS'({pixel_next.pixel_color, pixel_next.write_enable,
                                      pixel_next.pixel_y, pixel_next.pixel_x});
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                walk_reg <= walk_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
            m_last_reg <= pixel_next.last;
            m_user_reg <= pixel_next.idle;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && (m_tdata == '0))
        else $error("idle pixel carries data");

    a_idle_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !walk_reg.busy && !s_tdata[0] |=> m_tvalid && m_tuser)
        else $error("idle walk produced a pixel");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && pixel_next.last |=> !walk_reg.busy)
        else $error("walk still busy after last pixel");

    a_color_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2*SPAN_BITS] |->
            (m_tdata[2*SPAN_BITS+COLOR_BITS:2*SPAN_BITS+1] == '0))
        else $error("colour on a masked pixel");

endmodule
